### design/vdbd_pkg.sv
// Package for the voice DPCM block decoder: shared types, state codes and
// the sample expansion, zigzag and nibble-step functions. No dependencies.

package vdbd_pkg;

    // Block mode of the decoder.
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_DIRECT = 2'd1,
        MODE_DPCM   = 2'd2
    } mode_t;

    // Escape sequence progress inside a DPCM block.
    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_LOW  = 2'd1,
        ESC_HIGH = 2'd2
    } esc_t;

    // Input command codes.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Nibble value that opens an escaped 8-bit code.
    localparam logic [3:0] NIB_ESCAPE = 4'hf;

    // One result item.
    typedef struct packed {
        logic [15:0] sample;
        logic        silent;
        logic        last;
    } result_t;

    // Up to two results produced by one input item, handed to the output buffer.
    typedef struct packed {
        result_t    r0;
        result_t    r1;
        logic [1:0] count;
    } pair_req_t;

    // DPCM decode state that one nibble step updates.
    typedef struct packed {
        logic [7:0] acc;
        esc_t       esc;
        logic [3:0] lo;
    } dpcm_st_t;

    typedef struct packed {
        dpcm_st_t    st;
        logic        fire;
        logic [15:0] sample;
    } nib_res_t;

    // Expand 8 to 16 bits: sign(n)(2n^2-1), n=x-128; x=00: 8000, x=ff: 7fff.
    function automatic logic [15:0] vdbd_expand(logic [7:0] x);
        logic [6:0]  mag;
        logic [13:0] sq;
        logic [14:0] v;
        logic [15:0] res;
        mag = x[7] ? x[6:0] : 7'(~x[6:0] + 7'd1);
        sq  = 14'(mag) * 14'(mag);
        v   = {sq, 1'b0} - 15'd1;
        if (x == 8'h80) begin
            res = 16'h0000;
        end else if (x == 8'h00) begin
            res = 16'h8000;
        end else if (x == 8'hff) begin
            res = 16'h7fff;
        end else if (x[7]) begin
            res = {1'b0, v};
        end else begin
            res = 16'(~{1'b0, v} + 16'd1);
        end
        return res;
    endfunction

    // Zigzag map: even codes give c/2, odd codes give -(c+1)/2 modulo 256.
    function automatic logic [7:0] vdbd_zigzag(logic [7:0] c);
        logic [7:0] half;
        half = {1'b0, c[7:1]};
        return c[0] ? 8'(~half) : half;
    endfunction

    // One DPCM nibble step. When en is low the state passes unchanged.
    function automatic nib_res_t vdbd_nibble(dpcm_st_t st, logic [3:0] nib, logic en);
        nib_res_t   r;
        logic [7:0] code;
        r.st     = st;
        r.fire   = 1'b0;
        r.sample = 16'h0000;
        code     = {4'h0, nib};
        if (en) begin
            unique case (st.esc)
                ESC_LOW:
                begin
                    r.st.lo  = nib;
                    r.st.esc = ESC_HIGH;
                end
                ESC_HIGH:
                begin
                    code     = {nib, st.lo};
                    r.st.esc = ESC_NONE;
                    r.fire   = 1'b1;
                end
                default:
                begin
                    if (nib == NIB_ESCAPE) begin
                        r.st.esc = ESC_LOW;
                    end else begin
                        r.fire = 1'b1;
                    end
                end
            endcase
            if (r.fire) begin
                r.st.acc = st.acc - vdbd_zigzag(code);
                r.sample = vdbd_expand(r.st.acc);
            end
        end
        return r;
    endfunction

endpackage

### design/voice_dpcm_block_decoder.sv
// Top level of the voice DPCM block decoder: stream ports around the decode
// core and the output buffer. Depends on vdbd_pkg, vdbd_core and vdbd_out.
//
//   Channel   Direction  Handshake          Payload
//   s_*       in         s_tvalid/s_tready  tdata: block_length, data_byte; tuser: command
//   m_*       out        m_tvalid/m_tready  tdata: sample; tuser: silent_block; tlast: last
//
// An item is held in the input register and decoded in one pass; its results
// are loaded into the registered output buffer, which sends one result a cycle
// while m_tready is high. A DPCM byte can give two samples, every other item
// at most one. An item with results waits in the input register, with s_tready
// low, until the buffer is empty or sends its last result in that cycle, so
// m_tready reaches s_tready through logic. Reset clears the block state to idle.

module voice_dpcm_block_decoder
    import vdbd_pkg::*;
#(
    parameter int SAMPLES_PER_BLOCK = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] block_length, [23:16] data_byte
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample
    output logic        m_tuser,   // [0] silent_block
    output logic        m_tlast
);

    logic      load;
    logic      load_ok;
    pair_req_t pair;
    result_t   out_res;

    // Decode core.
    vdbd_core #(
        .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tuser),
        .in_length  (s_tdata[15:0]),
        .in_byte    (s_tdata[23:16]),
        .load_ok    (load_ok),
        .load       (load),
        .pair       (pair)
    );

    // Result buffer.
    vdbd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .pair      (pair),
        .load_ok   (load_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.sample;
    assign m_tuser = out_res.silent;
    assign m_tlast = out_res.last;

endmodule

### design/vdbd_core.sv
// Decoder core: input register, block state and the single-pass decode of
// one item into up to two results. Depends on vdbd_pkg.

module vdbd_core
    import vdbd_pkg::*;
#(
    parameter int SAMPLES_PER_BLOCK = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_command,
    input  logic [15:0] in_length,
    input  logic [7:0]  in_byte,
    input  logic        load_ok,
    output logic        load,
    output pair_req_t   pair
);

    localparam int SD_W = $clog2(SAMPLES_PER_BLOCK) + 1;
    localparam logic [SD_W-1:0] SD_LIMIT = SD_W'(SAMPLES_PER_BLOCK);

    // Input register.
    logic        valid_reg;
    logic        cmd_reg;
    logic [15:0] len_reg;
    logic [7:0]  byte_reg;

    // Block state.
    mode_t           mode_reg, mode_next;
    dpcm_st_t        st_reg, st_next;
    logic [15:0]     bytes_left_reg, bytes_left_next;
    logic [SD_W-1:0] sd_reg, sd_next;

    logic            advance;
    nib_res_t        nib0, nib1;
    logic [SD_W-1:0] sd_mid;
    logic [15:0]     bl_dec;
    result_t         res0, res1;
    logic [1:0]      count;

    // Decode of the registered item against the block state.
    always_comb
    begin
        mode_next       = mode_reg;
        st_next         = st_reg;
        bytes_left_next = bytes_left_reg;
        sd_next         = sd_reg;
        res0            = '0;
        res1            = '0;
        count           = 2'd0;
        bl_dec          = bytes_left_reg - 16'd1;

        nib0   = vdbd_nibble(st_reg, byte_reg[3:0], sd_reg < SD_LIMIT);
        sd_mid = sd_reg + SD_W'(nib0.fire);
        nib1   = vdbd_nibble(nib0.st, byte_reg[7:4], sd_mid < SD_LIMIT);

        if (cmd_reg == CMD_START) begin
            st_next         = '{acc: 8'h00, esc: ESC_NONE, lo: 4'h0};
            sd_next         = '0;
            bytes_left_next = len_reg;
            if (len_reg == 16'd0) begin
                mode_next   = MODE_IDLE;
                res0.silent = 1'b1;
                count       = 2'd1;
            end else if (len_reg == 16'(SAMPLES_PER_BLOCK)) begin
                mode_next = MODE_DIRECT;
            end else begin
                mode_next = MODE_DPCM;
            end
        end else if (mode_reg == MODE_IDLE || bytes_left_reg == 16'd0) begin
            mode_next = MODE_IDLE;
        end else begin
            bytes_left_next = bl_dec;
            if (mode_reg == MODE_DIRECT) begin
                if (sd_reg < SD_LIMIT) begin
                    sd_next     = sd_reg + SD_W'(1);
                    res0.sample = vdbd_expand(byte_reg);
                    count       = 2'd1;
                end
            end else begin
                st_next = nib1.st;
                sd_next = sd_mid + SD_W'(nib1.fire);
                if (nib0.fire) begin
                    res0.sample = nib0.sample;
                    res1.sample = nib1.sample;
                    count       = nib1.fire ? 2'd2 : 2'd1;
                end else if (nib1.fire) begin
                    res0.sample = nib1.sample;
                    count       = 2'd1;
                end
            end
            if (bl_dec == 16'd0) begin
                mode_next   = MODE_IDLE;
                st_next.esc = ESC_NONE;
            end
        end

        res0.last = (count == 2'd1);
        res1.last = 1'b1;
    end

    // An item leaves the input register once its results have room.
    assign advance    = valid_reg && (count == 2'd0 || load_ok);
    assign in_ready   = !valid_reg || advance;
    assign load       = advance && (count != 2'd0);
    assign pair.r0    = res0;
    assign pair.r1    = res1;
    assign pair.count = count;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    // Input payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            cmd_reg  <= in_command;
            len_reg  <= in_length;
            byte_reg <= in_byte;
        end
    end

    // Block state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_IDLE;
            st_reg         <= '{acc: 8'h00, esc: ESC_NONE, lo: 4'h0};
            bytes_left_reg <= 16'd0;
            sd_reg         <= '0;
        end else if (advance) begin
            mode_reg       <= mode_next;
            st_reg         <= st_next;
            bytes_left_reg <= bytes_left_next;
            sd_reg         <= sd_next;
        end
    end

    // A block never produces more samples than its limit.
    assert property (@(posedge clk) disable iff (!rst_n) sd_reg <= SD_LIMIT)
        else $error("sample count passed the block limit");

    // A decode that leaves idle mode has bytes left to consume.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_IDLE) |-> (bytes_left_reg != 16'd0))
        else $error("active block with no bytes left");

    // A start request never produces more than the one silent result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg == CMD_START) |-> (count == 2'd0 || (count == 2'd1 && res0.silent)))
        else $error("start request produced a sample");

endmodule

### design/vdbd_out.sv
// Output buffer: holds up to two results of one item and presents them one
// per cycle on the result stream while out_ready is high. Depends on vdbd_pkg.

module vdbd_out
    import vdbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  pair_req_t pair,
    output logic      load_ok,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   out_res
);

    logic [1:0] cnt_reg;
    result_t    slot0_reg;
    result_t    slot1_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign load_ok   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
    assign out_res   = slot0_reg;

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= pair.count;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Result slots: the head shows slot 0, slot 1 moves up when it is taken.
    always_ff @(posedge clk)
    begin
        if (load) begin
            slot0_reg <= pair.r0;
            slot1_reg <= pair.r1;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

    // A new pair is loaded only when the buffer is empty or sends its last result in that cycle.
    assert property (@(posedge clk) disable iff (!rst_n) load |-> load_ok)
        else $error("result pair loaded over pending results");

    // The buffer never holds more than two results.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("output buffer overfilled");

    // Taking the first of two results leaves the second on show.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cnt_reg == 2'd2) |=> (out_valid && cnt_reg == 2'd1))
        else $error("second result lost");

endmodule
